// ----- sv/atcw_pkg.sv -----
// atcw_pkg: shared types and constants of the adaptive threshold block
// no dependencies; imported by every module of the block but atcw_ram
`default_nettype none
package atcw_pkg;

  // widths sized for the largest parameter values the block supports
  localparam int COL_W  = 13;  // column, up to 4096
  localparam int ROW_W  = 11;  // row, up to 1024
  localparam int SLOT_W = 6;   // line store row slot, up to 48 rows
  localparam int WIN_W  = 6;   // window side, up to 32
  localparam int CNT_W  = 11;  // window pixel count, up to 1024
  localparam int SUM_W  = 18;  // sum of up to 1024 bytes
  localparam int MAX_HEIGHT = 1024;

  localparam logic [1:0] METH_MEAN     = 2'd0;
  localparam logic [1:0] METH_MEDIAN   = 2'd1;
  localparam logic [1:0] METH_MIDRANGE = 2'd2;

  localparam logic [2:0] REG_METHOD = 3'd0;
  localparam logic [2:0] REG_WINDOW = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [7:0]        pixel;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [WIN_W-1:0]  half;
    logic [WIN_W-1:0]  nx;
    logic [WIN_W-1:0]  ny;
    logic [CNT_W-1:0]  count;
    logic [1:0]        method;
    logic [4:0]        offset;
  } atcw_job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_PREP, ST_SCAN, ST_DRAIN, ST_PASS, ST_DIV, ST_OUT
  } atcw_state_t;

endpackage
`default_nettype wire

// ----- sv/atcw_ram.sv -----
// atcw_ram: generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module atcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/atcw_front.sv -----
// atcw_front: raster position tracking and window classification per pixel
// depends on atcw_pkg
`default_nettype none
module atcw_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 20,
  parameter int STORE_ROWS = 30
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          pixel,
  input  wire logic                frame_start,
  input  wire logic [1:0]          method,
  input  wire logic [4:0]          window_size,
  input  wire logic [4:0]          offset,
  input  wire logic [10:0]         image_width,
  input  wire logic [10:0]         image_height,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output atcw_pkg::atcw_job_t      job
);
  import atcw_pkg::*;

  logic [COL_W-1:0]  col, col_use, col_inc, w;
  logic [ROW_W-1:0]  row, row_use, row_inc, h, rowlim;
  logic [SLOT_W-1:0] slot, slot_use, slot_inc;
  logic [WIN_W-1:0]  size, half, nx, ny;
  logic [COL_W-1:0]  xspan;
  logic [ROW_W-1:0]  yspan;
  logic              take;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign take      = in_valid && job_ready;

  always_comb begin
    if (image_width == 11'd0) w = COL_W'(1);
    else if (COL_W'(image_width) > COL_W'(MAX_WIDTH)) w = COL_W'(MAX_WIDTH);
    else w = COL_W'(image_width);
    if (image_height == 11'd0) h = ROW_W'(1);
    else if (image_height > ROW_W'(MAX_HEIGHT)) h = ROW_W'(MAX_HEIGHT);
    else h = image_height;

    // stale position wraps before use
    col_use = (frame_start || col >= w) ? '0 : col;
    if (frame_start || row >= h) begin
      row_use  = '0;
      slot_use = '0;
    end else begin
      row_use  = row;
      slot_use = slot;
    end

    size = (WIN_W'(window_size) > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                      : WIN_W'(window_size);
    half = size >> 1;
    rowlim = (row_use > ROW_W'(STORE_ROWS - 1)) ? ROW_W'(STORE_ROWS - 1) : row_use;

    xspan = col_use - COL_W'(half) + COL_W'(1);
    if (col_use < COL_W'(half)) nx = '0;
    else if (xspan > COL_W'(size)) nx = size;
    else nx = WIN_W'(xspan);

    yspan = rowlim - ROW_W'(half) + ROW_W'(1);
    if (rowlim < ROW_W'(half)) ny = '0;
    else if (yspan > ROW_W'(size)) ny = size;
    else ny = WIN_W'(yspan);

    job.pixel  = pixel;
    job.col    = col_use;
    job.slot   = slot_use;
    job.half   = half;
    job.nx     = nx;
    job.ny     = ny;
    job.count  = CNT_W'(nx) * CNT_W'(ny);
    job.method = method;
    job.offset = offset;

    col_inc  = col_use + COL_W'(1);
    row_inc  = row_use + ROW_W'(1);
    slot_inc = (slot_use == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_use + SLOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (take) begin
      if (col_inc >= w) begin
        col <= '0;
        if (row_inc >= h) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row_inc;
          slot <= slot_inc;
        end
      end else begin
        col  <= col_inc;
        row  <= row_use;
        slot <= slot_use;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/atcw_queue.sv -----
// atcw_queue: two-entry job queue between front and back
// depends on atcw_pkg
`default_nettype none
module atcw_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  atcw_pkg::atcw_job_t  in_job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output atcw_pkg::atcw_job_t  out_job
);
  import atcw_pkg::*;

  atcw_job_t   mem [2];
  logic        wptr, rptr;
  logic [1:0]  cnt;
  logic        push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_job   = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/atcw_back.sv -----
// atcw_back: line store update, window scan, statistic and threshold per job
// depends on atcw_pkg and atcw_ram
`default_nettype none
module atcw_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int STORE_ROWS = 30
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  atcw_pkg::atcw_job_t  job_in,
  output logic                 m_valid,
  input  wire logic            m_ready,
  output logic [15:0]          m_data
);
  import atcw_pkg::*;

  localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  atcw_state_t       state, state_next;
  atcw_job_t         job;
  logic [WIN_W-1:0]  dxc, dyc, prep;
  logic [SLOT_W-1:0] slot_cur, slot_base, slot_dec;
  logic [2:0]        pass;
  logic [7:0]        prefix, hi_mask, rd_data, stat;
  logic [CNT_W-1:0]  rank, c0;
  logic [SUM_W-1:0]  sum, dvd;
  logic [CNT_W:0]    rem, rem_sh;
  logic [4:0]        div_cnt;
  logic [7:0]        vmax, vmin;
  logic [8:0]        mid_sum;
  logic signed [8:0] thr;
  logic              rd_pend, is_med, is_mid, scan_last, out_free, fg;
  logic              ram_we;
  logic [AW-1:0]     waddr, raddr;
  logic [COL_W-1:0]  rx;

  assign is_med    = (job.method == METH_MEDIAN);
  assign is_mid    = (job.method == METH_MIDRANGE);
  assign scan_last = (dxc == job.nx - WIN_W'(1)) && (dyc == job.ny - WIN_W'(1));
  assign out_free  = !m_valid || m_ready;
  assign slot_dec  = (slot_cur == '0) ? SLOT_W'(STORE_ROWS - 1) : slot_cur - SLOT_W'(1);
  assign hi_mask   = 8'hFF << (pass + 4'd1);
  assign rem_sh    = {rem[CNT_W-1:0], dvd[SUM_W-1]};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (job_valid) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_PREP;
      ST_PREP: begin
        if (prep == '0) state_next = (job.count == '0) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_PASS;
      ST_PASS: begin
        if (is_med) state_next = (pass == 3'd0) ? ST_OUT : ST_SCAN;
        else if (is_mid) state_next = ST_OUT;
        else state_next = ST_DIV;
      end
      ST_DIV:   if (div_cnt == 5'd0) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == ST_IDLE);
    ram_we    = (state == ST_WRITE);
    waddr     = AW'(job.slot * MAX_WIDTH + job.col);
    rx        = job.col - COL_W'(job.half) - COL_W'(dxc);
    raddr     = AW'(slot_cur * MAX_WIDTH + rx);
  end

  atcw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (job.pixel),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    mid_sum = {1'b0, vmax} + {1'b0, vmin};
    if (is_mid) stat = mid_sum[8:1];
    else if (is_med) stat = prefix;
    else stat = dvd[7:0];
    if (job.count == '0 && !is_mid) thr = '0;
    else thr = $signed({1'b0, stat}) - $signed({4'b0, job.offset});
    fg = $signed({1'b0, job.pixel}) < thr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      if (state == ST_OUT && out_free) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (job_valid) job <= job_in;
      end
      ST_WRITE: begin
        slot_cur <= job.slot;
        prep     <= job.half;
        vmax     <= job.pixel;
        vmin     <= job.pixel;
        sum      <= '0;
        c0       <= '0;
        pass     <= 3'd7;
        prefix   <= '0;
        rank     <= job.count >> 1;
        dxc      <= '0;
        dyc      <= '0;
      end
      ST_PREP: begin
        // step back half rows to the nearest window row
        if (prep != '0) begin
          prep     <= prep - WIN_W'(1);
          slot_cur <= slot_dec;
        end else begin
          slot_base <= slot_cur;
        end
      end
      ST_SCAN: begin
        if (dxc == job.nx - WIN_W'(1)) begin
          dxc      <= '0;
          dyc      <= dyc + WIN_W'(1);
          slot_cur <= slot_dec;
        end else begin
          dxc <= dxc + WIN_W'(1);
        end
      end
      ST_PASS: begin
        // one bit of the ranked value per pass, msb first
        if (rank >= c0) begin
          prefix[pass] <= 1'b1;
          rank         <= rank - c0;
        end
        pass     <= pass - 3'd1;
        c0       <= '0;
        dxc      <= '0;
        dyc      <= '0;
        slot_cur <= slot_base;
        dvd      <= sum;
        rem      <= '0;
        div_cnt  <= 5'(SUM_W - 1);
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, job.count}) begin
          rem <= rem_sh - {1'b0, job.count};
          dvd <= {dvd[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[SUM_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 5'd1;
      end
      ST_OUT: begin
        if (out_free) m_data <= {6'd0, thr, fg};
      end
      default: ;
    endcase
    if (rd_pend) begin
      sum <= sum + SUM_W'(rd_data);
      if (rd_data > vmax) vmax <= rd_data;
      if (rd_data < vmin) vmin <= rd_data;
      if ((((rd_data ^ prefix) & hi_mask) == 8'd0) && !rd_data[pass]) begin
        c0 <= c0 + CNT_W'(1);
      end
    end
  end

  a_write_only_at_start: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (state == ST_PREP))
    else $error("store written outside the item start");
  a_scan_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (dxc < job.nx) && (dyc < job.ny))
    else $error("scan left the window");
  a_read_follows_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == ST_SCAN))
    else $error("read data without a scan cycle");
  a_no_empty_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (job.count != '0))
    else $error("scan of an empty window");
endmodule
`default_nettype wire

// ----- sv/adaptive_threshold_causal_window_core.sv -----
// adaptive_threshold_causal_window_core: top level, config registers and wiring
// depends on atcw_pkg, atcw_front, atcw_queue, atcw_back, atcw_ram
//
// channel   dir   handshake            payload
// s_axis    in    s_tvalid/s_tready    tdata: pixel; tuser: frame_start
// m_axis    out   m_tvalid/m_tready    tdata: foreground, threshold
// cfg       in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one result beat per pixel beat; the back end runs one pixel at a time, with a
// window scan per pixel for midrange and mean (plus 18 divider steps for mean),
// eight scans for median and no scan for an empty window; one window pixel per
// cycle through the single store read port and one median pass per result bit.
// synchronous reset clears position, queue and handshakes and loads the default settings; the store needs no clear.
// the front takes up to two beats ahead while the back end or the output stalls.
`default_nettype none
module adaptive_threshold_causal_window_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 20,
  parameter int STORE_ROWS = 30
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel
  input  wire logic        s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] foreground, [9:1] threshold, [15:10] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import atcw_pkg::*;

  logic [1:0]  method;
  logic [4:0]  window_size, offset;
  logic [10:0] image_width, image_height;
  atcw_job_t   f_job, q_job;
  logic        f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      method       <= METH_MEAN;
      window_size  <= 5'd5;
      offset       <= 5'd7;
      image_width  <= 11'd640;
      image_height <= 11'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_METHOD: method       <= cfg_data[1:0];
        REG_WINDOW: window_size  <= cfg_data[4:0];
        REG_OFFSET: offset       <= cfg_data[4:0];
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  atcw_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW), .STORE_ROWS(STORE_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pixel        (s_tdata),
    .frame_start  (s_tuser),
    .method       (method),
    .window_size  (window_size),
    .offset       (offset),
    .image_width  (image_width),
    .image_height (image_height),
    .job_valid    (f_valid),
    .job_ready    (f_ready),
    .job          (f_job)
  );

  atcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  atcw_back #(.MAX_WIDTH(MAX_WIDTH), .STORE_ROWS(STORE_ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_in    (q_job),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_data    (m_tdata)
  );
endmodule
`default_nettype wire

// ----- tb/tb_adaptive_threshold_causal_window_core.sv -----
// testbench for adaptive_threshold_causal_window_core: drives pixel beats, register
// writes and random output stalls, and checks every result beat against its own predictor
// depends on atcw_pkg and the block's rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_adaptive_threshold_causal_window_core;
  import atcw_pkg::*;

  localparam int STORE_ROWS = 30;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 20;

  class threshold_scoreboard;
    logic [1:0]  method;
    logic [4:0]  win_size;
    logic [4:0]  offs;
    logic [10:0] width;
    logic [10:0] height;
    logic [7:0]  rows [STORE_ROWS*MAX_WIDTH];
    int          col;
    int          row;
    logic [15:0] pending [$];
    int          errors;

    function new();
      method = METH_MEAN;
      win_size = 5;
      offs = 7;
      width = 640;
      height = 480;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [10:0] val);
      case (idx)
        REG_METHOD: method = val[1:0];
        REG_WINDOW: win_size = val[4:0];
        REG_OFFSET: offs = val[4:0];
        REG_WIDTH:  width = val;
        REG_HEIGHT: height = val;
        default: ;
      endcase
    endfunction

    // works out the threshold for one accepted pixel and queues the result beat
    function void note_pixel(logic [7:0] pix, logic fs);
      int w, h, sz, half, cnt, sum, vmax, vmin, thr, dx, dy, v, rank, cum;
      int hist [256];
      w = (width < 1) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width;
      h = (height < 1) ? 1 : (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      rows[(row % STORE_ROWS) * MAX_WIDTH + col] = pix;
      sz = (win_size > MAX_WINDOW) ? MAX_WINDOW : win_size;
      half = sz / 2;
      cnt = 0;
      sum = 0;
      vmax = pix;
      vmin = pix;
      foreach (hist[i]) hist[i] = 0;
      for (int k = 0; k < sz; k++) begin
        dx = half + k;
        if (dx <= col) begin
          for (int l = 0; l < sz; l++) begin
            dy = half + l;
            if (dy <= row && dy < STORE_ROWS) begin
              v = rows[((row - dy) % STORE_ROWS) * MAX_WIDTH + (col - dx)];
              hist[v]++;
              sum += v;
              cnt++;
              if (v > vmax) vmax = v;
              if (v < vmin) vmin = v;
            end
          end
        end
      end
      if (method == METH_MIDRANGE) begin
        thr = (vmax + vmin) / 2 - offs;
      end else if (method == METH_MEDIAN) begin
        if (cnt == 0) begin
          thr = 0;
        end else begin
          rank = cnt / 2;
          cum = 0;
          v = 0;
          while (v < 256) begin
            cum += hist[v];
            if (cum > rank) break;
            v++;
          end
          if (v > 255) v = 255;
          thr = v - offs;
        end
      end else begin
        thr = (cnt == 0) ? 0 : sum / cnt - offs;
      end
      pending.push_back({6'b0, thr[8:0], (int'(pix) < thr) ? 1'b1 : 1'b0});
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [15:0] beat);
      logic [15:0] exp_beat;
      if (pending.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", beat));
      end else begin
        exp_beat = pending.pop_front();
        if (beat[0] !== exp_beat[0])
          report($sformatf("foreground %b, expected %b", beat[0], exp_beat[0]));
        if (beat[9:1] !== exp_beat[9:1])
          report($sformatf("threshold %0d, expected %0d",
                           $signed(beat[9:1]), $signed(exp_beat[9:1])));
        if (beat[15:10] !== 6'b0)
          report($sformatf("pad bits %h not zero", beat[15:10]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_METHOD;
  logic [10:0] cfg_data = 11'd0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         cfg_ready;

  threshold_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int pixels_sent = 0;

  adaptive_threshold_causal_window_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stall per beat, ready stays high between beats with no stall
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
    end
  end

  task send_pixel(logic [7:0] pix, logic fs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= fs;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(pix, fs);
    pixels_sent++;
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // valid stays high across back to back writes; the caller drops it after the last
  task write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  function logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(252, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame-aligned run at a given setting; the store is only read where written
  task run_frame(logic [1:0] meth, logic [4:0] win, logic [4:0] off,
                 logic [10:0] w, logic [10:0] h, int n, bit burst, bit hold);
    wait_drained();
    repeat (10) @(posedge clk);
    write_reg(REG_METHOD, 11'(meth));
    write_reg(REG_WINDOW, 11'(win));
    write_reg(REG_OFFSET, 11'(off));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
    no_gaps = burst;
    for (int i = 0; i < n; i++) begin
      if (hold && i == n / 2) wait_drained();
      send_pixel(pick_pixel(), (i == 0) || ($urandom_range(0, 150) == 0));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting, pixel extremes and a mid-run frame start
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd7, 1'b0);

    run_frame(METH_MEAN, 5, 7, 16, 12, 100, 1'b0, 1'b1);
    run_frame(METH_MEDIAN, 5, 3, 16, 12, 100, 1'b0, 1'b0);
    run_frame(METH_MIDRANGE, 7, 0, 9, 9, 80, 1'b1, 1'b0);
    run_frame(2'd3, 3, 20, 12, 6, 60, 1'b0, 1'b0);
    run_frame(METH_MEDIAN, 0, 31, 7, 5, 30, 1'b0, 1'b0);
    run_frame(METH_MEAN, 31, 4, 24, 40, 40, 1'b0, 1'b0);
    // rows more than the store depth back fall out of the window
    run_frame(METH_MEAN, 9, 2, 2, 11'd2047, 100, 1'b0, 1'b0);
    run_frame(METH_MEDIAN, 20, 10, 3, 64, 40, 1'b0, 1'b0);
    run_frame(METH_MIDRANGE, 1, 1, 0, 1, 60, 1'b1, 1'b0);
    run_frame(METH_MEAN, 1, 0, 1024, 1024, 40, 1'b0, 1'b0);
    run_frame(METH_MEDIAN, 4, 6, 11'd2047, 0, 40, 1'b0, 1'b0);
    while (pixels_sent < 850)
      run_frame(2'($urandom_range(0, 3)), 5'($urandom_range(0, 9)),
                5'($urandom_range(0, 31)), 11'($urandom_range(1, 40)),
                11'($urandom_range(1, 40)), int'($urandom_range(40, 100)),
                $urandom_range(0, 3) == 0, 1'b0);

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
